FILE: design/smtq_pkg.sv
package smtq_pkg;

	localparam int NUM_TIMERS_DEF = 32;
	localparam int MAX_EXPIRE = 32;
	localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_ALLOC = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_BIND = 3'd3;
	localparam logic [2:0] OP_ARM = 3'd4;
	localparam logic [2:0] OP_CANCEL = 3'd5;
	localparam logic [2:0] OP_CANCEL_DEST = 3'd6;

	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_EXPIRE = 2'd1;
	localparam logic [1:0] KIND_SWITCH = 2'd2;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;

	localparam logic REG_SW_SLOT = 1'b0;
	localparam logic REG_SW_ENABLE = 1'b1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [4:0] slot;
		logic [31:0] delay;
		logic [7:0] dest_id;
		logic signed [31:0] payload;
		logic auto_cancel;
	} smtq_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] out_slot;
		logic [7:0] out_dest;
		logic signed [31:0] out_payload;
		logic ok;
		logic last;
	} smtq_rsp_t;

	typedef struct packed {
		logic [4:0] sw_slot;
		logic sw_en;
	} smtq_cfg_t;

endpackage

FILE: design/smtq_ifs.sv
interface smtq_req_if;
	import smtq_pkg::*;
	logic valid;
	logic ready;
	smtq_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smtq_rsp_if;
	import smtq_pkg::*;
	logic valid;
	logic ready;
	smtq_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/smtq_store.sv
module smtq_store #(
	parameter int NUM_TIMERS = 32,
	localparam int IW = $clog2(NUM_TIMERS)
) (
	input logic clk,
	input logic [IW-1:0] raddr,
	output logic [IW-1:0] rd_next,
	output logic [31:0] rd_dl,
	output logic [7:0] rd_dest,
	output logic [31:0] rd_pay,
	input logic dl_we,
	input logic [IW-1:0] dl_wa,
	input logic [31:0] dl_wd,
	input logic nx_we,
	input logic [IW-1:0] nx_wa,
	input logic [IW-1:0] nx_wd,
	input logic bd_we,
	input logic [IW-1:0] bd_wa,
	input logic [7:0] bd_dest,
	input logic [31:0] bd_pay
);

	logic [IW-1:0] next_mem [NUM_TIMERS];
	logic [31:0] dl_mem [NUM_TIMERS];
	logic [7:0] dest_mem [NUM_TIMERS];
	logic [31:0] pay_mem [NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (dl_we) dl_mem[dl_wa] <= dl_wd;
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (bd_we) begin
			dest_mem[bd_wa] <= bd_dest;
			pay_mem[bd_wa] <= bd_pay;
		end
		rd_next <= next_mem[raddr];
		rd_dl <= dl_mem[raddr];
		rd_dest <= dest_mem[raddr];
		rd_pay <= pay_mem[raddr];
	end

endmodule

FILE: design/smtq_cfg.sv
module smtq_cfg import smtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output smtq_cfg_t cfg
);

	smtq_cfg_t cfg_q;

	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SW_SLOT: cfg_q.sw_slot <= pwdata[4:0];
				REG_SW_ENABLE: cfg_q.sw_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SW_SLOT: prdata = {27'd0, cfg_q.sw_slot};
			REG_SW_ENABLE: prdata = {31'd0, cfg_q.sw_en};
			default: prdata = '0;
		endcase
	end

endmodule

FILE: design/smtq_seq.sv
module smtq_seq import smtq_pkg::*; #(
	parameter int NUM_TIMERS = 32,
	localparam int IW = $clog2(NUM_TIMERS),
	localparam int CW = $clog2(NUM_TIMERS + 1),
	localparam int RW = $clog2(MAX_EXPIRE + 1)
) (
	input logic clk,
	input logic arst_n,
	smtq_req_if.sink req,
	smtq_rsp_if.source rsp,
	input smtq_cfg_t cfg,
	output logic [IW-1:0] raddr,
	input logic [IW-1:0] rd_next,
	input logic [31:0] rd_dl,
	input logic [7:0] rd_dest,
	input logic [31:0] rd_pay,
	output logic dl_we,
	output logic [IW-1:0] dl_wa,
	output logic [31:0] dl_wd,
	output logic nx_we,
	output logic [IW-1:0] nx_wa,
	output logic [IW-1:0] nx_wd,
	output logic bd_we,
	output logic [IW-1:0] bd_wa,
	output logic [7:0] bd_dest,
	output logic [31:0] bd_pay
);

	typedef enum logic [4:0] {
		IDLE, S_RESP, T_CHK, T_POP, T_DL, T_END, T_SW, S_ALLOC, S_REL, S_REL2,
		S_BIND, S_ARM, S_ARM2, S_CAN, S_CAN2, C_RD, C_CHK, C_FREE,
		U_START, U_HEAD, U_HDL, U_WALK, U_LINK, I_START, I_WALK, I_CMP, I_FIX
	} state_t;

	state_t state_q, ret_q;
	smtq_req_t in_q;
	logic [IW-1:0] slot_q, tgt_q, cur_q, prev_q, fix_q, idx_q, head_q;
	logic sval_q, nonempty_q, sw_q, any_q, pend_v_q, resp_ok_q, ov_q;
	logic [CW-1:0] len_q, pos_q;
	logic [RW-1:0] removed_q;
	logic [31:0] tick_q, earliest_q, dnew_q, pend_pay_q;
	logic [IW-1:0] resp_slot_q, pend_slot_q;
	logic [7:0] pend_dest_q;
	logic [1:0] status_q [NUM_TIMERS];
	logic ac_q [NUM_TIMERS];
	smtq_rsp_t od_q;

	logic can_emit, head_is_sw, last_idx, pos_last, d_le_head, d_le_rd, dest_hit;

	assign can_emit = !ov_q || rsp.ready;
	assign head_is_sw = cfg.sw_en && (32'(head_q) == 32'(cfg.sw_slot));
	assign last_idx = (32'(idx_q) == NUM_TIMERS - 1);
	assign pos_last = ((pos_q + CW'(1)) == len_q);
	assign d_le_head = (dnew_q <= earliest_q);
	assign d_le_rd = (dnew_q <= rd_dl);
	assign dest_hit = (status_q[idx_q] != ST_FREE) && ac_q[idx_q] && (rd_dest == in_q.dest_id);

	assign req.ready = (state_q == IDLE);
	assign rsp.valid = ov_q;
	assign rsp.data = od_q;

	// Read address: the walking states follow the link just read.
	always_comb begin
		unique case (state_q)
			T_POP, U_HEAD, U_WALK, I_WALK, I_CMP: raddr = rd_next;
			C_RD: raddr = idx_q;
			default: raddr = head_q;
		endcase
	end

	always_comb begin
		dl_we = (state_q == S_ARM) && sval_q && (status_q[slot_q] != ST_FREE);
		dl_wa = slot_q;
		dl_wd = tick_q + in_q.delay;
		bd_we = (state_q == S_BIND) && sval_q;
		bd_wa = slot_q;
		bd_dest = in_q.dest_id;
		bd_pay = in_q.payload;
		nx_we = 1'b0;
		nx_wa = tgt_q;
		nx_wd = tgt_q;
		unique case (state_q)
			U_WALK: begin
				if (rd_next == tgt_q && pos_last) begin
					nx_we = 1'b1;
					nx_wa = cur_q;
					nx_wd = cur_q;
				end
			end
			U_LINK: begin
				nx_we = 1'b1;
				nx_wa = cur_q;
				nx_wd = rd_next;
			end
			I_START: begin
				nx_we = 1'b1;
				if (!nonempty_q) begin
					nx_wa = tgt_q;
					nx_wd = tgt_q;
				end else if (d_le_head) begin
					nx_wa = tgt_q;
					nx_wd = head_q;
				end else if (len_q == CW'(1)) begin
					nx_wa = head_q;
					nx_wd = tgt_q;
				end else begin
					nx_we = 1'b0;
				end
			end
			I_CMP: begin
				nx_we = d_le_rd || pos_last;
				nx_wa = d_le_rd ? prev_q : cur_q;
				nx_wd = tgt_q;
			end
			I_FIX: begin
				nx_we = 1'b1;
				nx_wa = tgt_q;
				nx_wd = fix_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ret_q <= IDLE;
			head_q <= '0;
			nonempty_q <= 1'b0;
			len_q <= '0;
			tick_q <= '0;
			earliest_q <= NO_DEADLINE;
			ov_q <= 1'b0;
			pend_v_q <= 1'b0;
			sw_q <= 1'b0;
			any_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= ST_FREE;
				ac_q[i] <= 1'b0;
			end
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						in_q <= req.data;
						slot_q <= IW'(req.data.slot);
						sval_q <= (32'(req.data.slot) < NUM_TIMERS);
						resp_ok_q <= 1'b0;
						resp_slot_q <= '0;
						idx_q <= '0;
						removed_q <= '0;
						sw_q <= 1'b0;
						any_q <= 1'b0;
						unique case (req.data.opcode)
							OP_TICK: begin
								tick_q <= tick_q + 32'd1;
								state_q <= T_CHK;
							end
							OP_ALLOC: state_q <= S_ALLOC;
							OP_RELEASE: state_q <= S_REL;
							OP_BIND: state_q <= S_BIND;
							OP_ARM: state_q <= S_ARM;
							OP_CANCEL: state_q <= S_CAN;
							OP_CANCEL_DEST: state_q <= C_RD;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RESP: begin
					if (can_emit) begin
						ov_q <= 1'b1;
						od_q <= '{KIND_DONE, 5'(resp_slot_q), 8'd0, 32'sd0, resp_ok_q, 1'b1};
						state_q <= IDLE;
					end
				end
				T_CHK: begin
					if (nonempty_q && removed_q < RW'(MAX_EXPIRE) && earliest_q <= tick_q) begin
						// An event is held back until it is known whether another follows.
						if (!head_is_sw && pend_v_q) begin
							if (can_emit) begin
								ov_q <= 1'b1;
								od_q <= '{KIND_EXPIRE, 5'(pend_slot_q), pend_dest_q,
									pend_pay_q, 1'b0, 1'b0};
								pend_v_q <= 1'b0;
								state_q <= T_POP;
							end
						end else begin
							state_q <= T_POP;
						end
					end else begin
						state_q <= T_END;
					end
				end
				T_POP: begin
					status_q[head_q] <= ST_ALLOC;
					removed_q <= removed_q + RW'(1);
					if (head_is_sw) begin
						sw_q <= 1'b1;
					end else begin
						pend_v_q <= 1'b1;
						any_q <= 1'b1;
						pend_slot_q <= head_q;
						pend_dest_q <= rd_dest;
						pend_pay_q <= rd_pay;
					end
					len_q <= len_q - CW'(1);
					if (len_q == CW'(1)) begin
						nonempty_q <= 1'b0;
						earliest_q <= NO_DEADLINE;
						state_q <= T_CHK;
					end else begin
						head_q <= rd_next;
						state_q <= T_DL;
					end
				end
				T_DL: begin
					earliest_q <= rd_dl;
					state_q <= T_CHK;
				end
				T_END: begin
					if (pend_v_q) begin
						if (can_emit) begin
							ov_q <= 1'b1;
							od_q <= '{KIND_EXPIRE, 5'(pend_slot_q), pend_dest_q,
								pend_pay_q, 1'b0, !sw_q};
							pend_v_q <= 1'b0;
							state_q <= T_SW;
						end
					end else begin
						state_q <= T_SW;
					end
				end
				T_SW: begin
					if (sw_q) begin
						if (can_emit) begin
							ov_q <= 1'b1;
							od_q <= '{KIND_SWITCH, cfg.sw_slot, 8'd0, 32'sd0, 1'b0, 1'b1};
							state_q <= IDLE;
						end
					end else begin
						state_q <= any_q ? IDLE : S_RESP;
					end
				end
				S_ALLOC: begin
					if (status_q[idx_q] == ST_FREE) begin
						status_q[idx_q] <= ST_ALLOC;
						ac_q[idx_q] <= 1'b0;
						resp_slot_q <= idx_q;
						resp_ok_q <= 1'b1;
						state_q <= S_RESP;
					end else if (last_idx) begin
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_REL: begin
					if (sval_q && status_q[slot_q] == ST_RUN) begin
						tgt_q <= slot_q;
						ret_q <= S_REL2;
						state_q <= U_START;
					end else begin
						if (sval_q) status_q[slot_q] <= ST_FREE;
						state_q <= S_RESP;
					end
				end
				S_REL2: begin
					status_q[slot_q] <= ST_FREE;
					state_q <= S_RESP;
				end
				S_BIND: begin
					if (sval_q) ac_q[slot_q] <= in_q.auto_cancel;
					state_q <= S_RESP;
				end
				S_ARM: begin
					if (sval_q && status_q[slot_q] != ST_FREE) begin
						dnew_q <= tick_q + in_q.delay;
						tgt_q <= slot_q;
						ret_q <= S_ARM2;
						state_q <= (status_q[slot_q] == ST_RUN) ? U_START : S_ARM2;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_ARM2: begin
					status_q[slot_q] <= ST_RUN;
					ret_q <= S_RESP;
					state_q <= I_START;
				end
				S_CAN: begin
					if (sval_q && status_q[slot_q] == ST_RUN) begin
						tgt_q <= slot_q;
						ret_q <= S_CAN2;
						state_q <= U_START;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_CAN2: begin
					status_q[slot_q] <= ST_ALLOC;
					resp_ok_q <= 1'b1;
					state_q <= S_RESP;
				end
				C_RD: state_q <= C_CHK;
				C_CHK: begin
					if (dest_hit && status_q[idx_q] == ST_RUN) begin
						tgt_q <= idx_q;
						ret_q <= C_FREE;
						state_q <= U_START;
					end else begin
						if (dest_hit) status_q[idx_q] <= ST_FREE;
						idx_q <= idx_q + IW'(1);
						state_q <= last_idx ? S_RESP : C_RD;
					end
				end
				C_FREE: begin
					status_q[tgt_q] <= ST_FREE;
					idx_q <= idx_q + IW'(1);
					state_q <= last_idx ? S_RESP : C_RD;
				end
				U_START: begin
					cur_q <= head_q;
					pos_q <= CW'(1);
					state_q <= (head_q == tgt_q) ? U_HEAD : U_WALK;
				end
				U_HEAD: begin
					len_q <= len_q - CW'(1);
					if (len_q == CW'(1)) begin
						nonempty_q <= 1'b0;
						earliest_q <= NO_DEADLINE;
						state_q <= ret_q;
					end else begin
						head_q <= rd_next;
						state_q <= U_HDL;
					end
				end
				U_HDL: begin
					earliest_q <= rd_dl;
					state_q <= ret_q;
				end
				U_WALK: begin
					if (rd_next == tgt_q) begin
						if (pos_last) begin
							len_q <= len_q - CW'(1);
							state_q <= ret_q;
						end else begin
							state_q <= U_LINK;
						end
					end else begin
						cur_q <= rd_next;
						pos_q <= pos_q + CW'(1);
					end
				end
				U_LINK: begin
					len_q <= len_q - CW'(1);
					state_q <= ret_q;
				end
				I_START: begin
					prev_q <= head_q;
					pos_q <= CW'(1);
					if (!nonempty_q) begin
						head_q <= tgt_q;
						nonempty_q <= 1'b1;
						len_q <= CW'(1);
						earliest_q <= dnew_q;
						state_q <= ret_q;
					end else if (d_le_head) begin
						head_q <= tgt_q;
						len_q <= len_q + CW'(1);
						earliest_q <= dnew_q;
						state_q <= ret_q;
					end else if (len_q == CW'(1)) begin
						fix_q <= tgt_q;
						state_q <= I_FIX;
					end else begin
						state_q <= I_WALK;
					end
				end
				I_WALK: begin
					cur_q <= rd_next;
					state_q <= I_CMP;
				end
				I_CMP: begin
					if (d_le_rd) begin
						fix_q <= cur_q;
						state_q <= I_FIX;
					end else if (pos_last) begin
						fix_q <= tgt_q;
						state_q <= I_FIX;
					end else begin
						prev_q <= cur_q;
						cur_q <= rd_next;
						pos_q <= pos_q + CW'(1);
					end
				end
				I_FIX: begin
					len_q <= len_q + CW'(1);
					state_q <= ret_q;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_len_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) == !nonempty_q) else $error("list length and empty flag disagree");
	a_empty_earliest: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty_q |-> earliest_q == NO_DEADLINE) else $error("empty list has a deadline");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == IDLE |-> !pend_v_q) else $error("expiry item left behind");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready) else $error("accepted while busy");

endmodule

FILE: design/sorted_multi_timer_queue.sv
// Allocate scans the slots for a free one, and cancel by destination scans every slot and
// unlinks each running hit; arm, cancel and release walk the sorted list entry by entry to
// unlink a running timer, and arm walks it again to insert; a tick expires due entries.
// Throughput: one item at a time; the next item is taken once the sequencer is back in idle.
// The one-entry result register lets the next item start while a result waits to be taken.
// Reset (arst_n low) frees all slots, empties the list and clears the tick count.
module sorted_multi_timer_queue import smtq_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input logic clk,
	input logic arst_n,
	smtq_req_if.sink req,
	smtq_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int IW = $clog2(NUM_TIMERS);

	smtq_cfg_t cfg;
	logic [IW-1:0] raddr, rd_next, nx_wa, nx_wd, dl_wa, bd_wa;
	logic [31:0] rd_dl, rd_pay, dl_wd, bd_pay;
	logic [7:0] rd_dest, bd_dest;
	logic dl_we, nx_we, bd_we;

	smtq_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	smtq_store #(.NUM_TIMERS(NUM_TIMERS)) u_store (
		.clk, .raddr, .rd_next, .rd_dl, .rd_dest, .rd_pay,
		.dl_we, .dl_wa, .dl_wd, .nx_we, .nx_wa, .nx_wd,
		.bd_we, .bd_wa, .bd_dest, .bd_pay
	);

	smtq_seq #(.NUM_TIMERS(NUM_TIMERS)) u_seq (
		.clk, .arst_n, .req, .rsp, .cfg,
		.raddr, .rd_next, .rd_dl, .rd_dest, .rd_pay,
		.dl_we, .dl_wa, .dl_wd, .nx_we, .nx_wa, .nx_wd,
		.bd_we, .bd_wa, .bd_dest, .bd_pay
	);

endmodule

FILE: tb/sv/sorted_multi_timer_queue_tb.sv
`timescale 1ns / 1ps

module sorted_multi_timer_queue_tb;
	import smtq_pkg::*;

	localparam int NT = NUM_TIMERS_DEF;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	smtq_req_if req ();
	smtq_rsp_if rsp ();

	sorted_multi_timer_queue #(.NUM_TIMERS(NT)) i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timer pool mirror.
	logic [1:0] t_status [NT];
	logic [31:0] t_deadline [NT];
	logic [7:0] t_dest [NT];
	logic [31:0] t_payload [NT];
	logic t_auto [NT];
	logic [31:0] now_ticks;
	logic [4:0] sw_slot;
	logic sw_en;
	bit was_bound [NT];
	int running [$];

	smtq_req_t pending_ops [$];
	smtq_rsp_t expected_rsp [$];
	int fail_count = 0;
	int accepted_ops = 0;
	int total_ops = 0;
	int idle_cycles = 0;
	bit stimulus_done = 0;

	function automatic smtq_rsp_t mk_rsp(logic [1:0] k, logic [4:0] s, logic [7:0] d,
			logic [31:0] p, logic ok);
		smtq_rsp_t r;
		r.kind = k;
		r.out_slot = s;
		r.out_dest = d;
		r.out_payload = p;
		r.ok = ok;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void unlink_slot(int s);
		foreach (running[i])
			if (running[i] == s) begin
				running.delete(i);
				return;
			end
	endfunction

	// Ties go in front of equal deadlines.
	function automatic void link_slot(int s);
		foreach (running[i])
			if (t_deadline[s] <= t_deadline[running[i]]) begin
				running.insert(i, s);
				return;
			end
		running.push_back(s);
	endfunction

	function automatic void predict_timer_op(smtq_req_t op);
		smtq_rsp_t res [$];
		smtq_rsp_t r;
		int s;
		int removed;
		bit sw;
		s = op.slot;
		r = mk_rsp(KIND_DONE, 0, 0, 0, 0);
		case (op.opcode)
			OP_TICK: begin
				sw = 0;
				removed = 0;
				now_ticks++;
				while (running.size() > 0 && removed < MAX_EXPIRE &&
						t_deadline[running[0]] <= now_ticks) begin
					s = running.pop_front();
					t_status[s] = ST_ALLOC;
					removed++;
					if (sw_en && s == sw_slot)
						sw = 1;
					else
						res.push_back(mk_rsp(KIND_EXPIRE, 5'(s), t_dest[s], t_payload[s], 0));
				end
				if (sw)
					res.push_back(mk_rsp(KIND_SWITCH, sw_slot, 0, 0, 0));
			end
			OP_ALLOC: begin
				for (int i = 0; i < NT; i++)
					if (t_status[i] == ST_FREE) begin
						t_status[i] = ST_ALLOC;
						t_auto[i] = 0;
						r.out_slot = 5'(i);
						r.ok = 1;
						break;
					end
			end
			OP_RELEASE: begin
				if (t_status[s] == ST_RUN)
					unlink_slot(s);
				t_status[s] = ST_FREE;
			end
			OP_BIND: begin
				t_dest[s] = op.dest_id;
				t_payload[s] = op.payload;
				t_auto[s] = op.auto_cancel;
				was_bound[s] = 1;
			end
			OP_ARM: begin
				if (t_status[s] != ST_FREE) begin
					if (t_status[s] == ST_RUN)
						unlink_slot(s);
					t_deadline[s] = now_ticks + op.delay;
					t_status[s] = ST_RUN;
					link_slot(s);
				end
			end
			OP_CANCEL: begin
				if (t_status[s] == ST_RUN) begin
					unlink_slot(s);
					t_status[s] = ST_ALLOC;
					r.ok = 1;
				end
			end
			OP_CANCEL_DEST: begin
				for (int i = 0; i < NT; i++)
					if (t_status[i] != ST_FREE && t_auto[i] && t_dest[i] == op.dest_id) begin
						if (t_status[i] == ST_RUN)
							unlink_slot(i);
						t_status[i] = ST_FREE;
					end
			end
			default: ;
		endcase
		if (res.size() == 0)
			res.push_back(r);
		res[res.size() - 1].last = 1'b1;
		foreach (res[i])
			expected_rsp.push_back(res[i]);
	endfunction

	// Driver. The accepted item is popped first, so the next one is always at the front.
	int req_gap = 0;
	always @(posedge clk) begin
		if (req.valid && req.ready) begin
			predict_timer_op(req.data);
			accepted_ops++;
			void'(pending_ops.pop_front());
		end
		if (req_gap > 0) begin
			req_gap <= req_gap - 1;
			req.valid <= 1'b0;
		end else if ((!req.valid || req.ready) && pending_ops.size() > 0) begin
			if ($urandom_range(0, 3) == 0 && !(req.valid && req.ready)) begin
				req_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				req.data <= pending_ops[0];
			end
		end else if (req.valid && req.ready) begin
			req.valid <= 1'b0;
		end
	end

	// Response monitor with random stalls.
	int rsp_gap = 0;
	always @(posedge clk) begin
		smtq_rsp_t want;
		if (rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected result kind=%0d slot=%0d", rsp.data.kind, rsp.data.out_slot);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.data.kind !== want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, rsp.data.kind);
					fail_count++;
				end
				if (rsp.data.out_slot !== want.out_slot) begin
					$error("out_slot: expected %0d actual %0d", want.out_slot, rsp.data.out_slot);
					fail_count++;
				end
				if (rsp.data.out_dest !== want.out_dest) begin
					$error("out_dest: expected %0d actual %0d", want.out_dest, rsp.data.out_dest);
					fail_count++;
				end
				if (rsp.data.out_payload !== want.out_payload) begin
					$error("out_payload: expected %0d actual %0d", want.out_payload,
						rsp.data.out_payload);
					fail_count++;
				end
				if (rsp.data.ok !== want.ok) begin
					$error("ok: expected %0d actual %0d", want.ok, rsp.data.ok);
					fail_count++;
				end
				if (rsp.data.last !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, rsp.data.last);
					fail_count++;
				end
			end
		end
		if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			rsp_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted item or taken result.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_multi_timer_queue test failed");
			$finish;
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SW_SLOT)
			sw_slot = val[4:0];
		else
			sw_en = val[0];
	endtask

	task automatic push_op(logic [2:0] code, logic [4:0] s, logic [31:0] d,
			logic [7:0] dst, logic [31:0] p, logic ac);
		smtq_req_t op;
		op.opcode = code;
		op.slot = s;
		op.delay = d;
		op.dest_id = dst;
		op.payload = p;
		op.auto_cancel = ac;
		pending_ops.push_back(op);
		total_ops++;
	endtask

	task automatic drain;
		wait (accepted_ops == total_ops && expected_rsp.size() == 0);
		repeat (4 * NT + 20) @(posedge clk);
	endtask

	// A slot is armed only after it has been bound, so no unbound expiry occurs.
	task automatic random_phase(int count);
		int s;
		int pick;
		logic [31:0] d;
		for (int n = 0; n < count; n++) begin
			s = $urandom_range(0, NT - 1);
			pick = $urandom_range(0, 99);
			if (pick < 25)
				push_op(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 37)
				push_op(OP_ALLOC, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 52) begin
				push_op(OP_BIND, s, $urandom, $urandom_range(0, 3), $urandom, $urandom);
				was_bound[s] = 1;
			end else if (pick < 75) begin
				if (!was_bound[s]) begin
					push_op(OP_BIND, s, $urandom, $urandom_range(0, 3), $urandom, $urandom);
					was_bound[s] = 1;
				end
				d = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 6);
				push_op(OP_ARM, s, d, $urandom, $urandom, $urandom);
			end else if (pick < 85)
				push_op(OP_CANCEL, s, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 92)
				push_op(OP_RELEASE, s, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 97)
				push_op(OP_CANCEL_DEST, s, $urandom, $urandom_range(0, 3), $urandom, $urandom);
			else
				push_op(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		now_ticks = '0;
		sw_slot = '0;
		sw_en = 1'b0;
		for (int i = 0; i < NT; i++) begin
			t_status[i] = ST_FREE;
			t_deadline[i] = '0;
			t_dest[i] = '0;
			t_payload[i] = '0;
			t_auto[i] = 1'b0;
			was_bound[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		reg_write(REG_SW_SLOT, 32'd2);
		reg_write(REG_SW_ENABLE, 32'd1);

		// Directed part: allocate, extreme fields, ties, switch timer, cancels.
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		push_op(OP_ARM, 5'd31, 32'd1, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			push_op(OP_ALLOC, 0, 0, 0, 0, 0);
		push_op(OP_BIND, 0, 0, 8'hff, 32'h7fff_ffff, 1);
		push_op(OP_BIND, 1, 0, 8'h00, 32'h8000_0000, 0);
		push_op(OP_BIND, 2, 0, 8'hff, 32'hffff_ffff, 1);
		push_op(OP_BIND, 3, 0, 8'h5a, 32'h0, 1);
		push_op(OP_ARM, 0, 32'd2, 0, 0, 0);
		push_op(OP_ARM, 1, 32'd2, 0, 0, 0);
		push_op(OP_ARM, 2, 32'd1, 0, 0, 0);
		push_op(OP_ARM, 3, 32'hffff_ffff, 0, 0, 0);
		push_op(OP_ARM, 1, 32'd1, 0, 0, 0);
		push_op(OP_CANCEL, 3, 0, 0, 0, 0);
		push_op(OP_CANCEL, 3, 0, 0, 0, 0);
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		push_op(OP_ARM, 3, 32'd0, 0, 0, 0);
		push_op(OP_RELEASE, 3, 0, 0, 0, 0);
		push_op(OP_ARM, 0, 32'd5, 0, 0, 0);
		push_op(OP_CANCEL_DEST, 0, 0, 8'hff, 0, 0);
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		push_op(3'd7, 5'd31, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1);
		drain();

		random_phase(15);
		drain();
		reg_write(REG_SW_SLOT, 32'd31);
		reg_write(REG_SW_ENABLE, 32'd1);

		// Fill the pool so allocate fails at least once, then many expiries in one tick.
		for (int i = 0; i < NT + 1; i++)
			push_op(OP_ALLOC, 0, 0, 0, 0, 0);
		for (int i = NT - 8; i < NT; i++) begin
			push_op(OP_BIND, i, 0, i, $urandom, 0);
			was_bound[i] = 1;
			push_op(OP_ARM, i, $urandom_range(1, 2), 0, 0, 0);
		end
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		push_op(OP_TICK, 0, 0, 0, 0, 0);
		drain();

		random_phase(15);
		drain();
		reg_write(REG_SW_ENABLE, 32'd0);
		reg_write(REG_SW_SLOT, 32'd0);
		random_phase(15);
		drain();
		stimulus_done = 1;

		if (fail_count == 0)
			$display("sorted_multi_timer_queue test passed");
		else
			$display("sorted_multi_timer_queue test failed");
		$finish;
	end

endmodule

FILE: sorted_multi_timer_queue.f
design/smtq_pkg.sv
design/smtq_ifs.sv
design/smtq_store.sv
design/smtq_cfg.sv
design/smtq_seq.sv
design/sorted_multi_timer_queue.sv
tb/sv/sorted_multi_timer_queue_tb.sv
